### hw/rtl/jwl_pkg.sv
// ----------------------------------------------------------------------------
// jwl_pkg
// Shared types, constants and exponential lookup data for the JWL evaluator.
// ----------------------------------------------------------------------------
package jwl_pkg;

  localparam int unsigned DivSteps = 51;
  localparam int unsigned NumLanes = 4;

  localparam int unsigned LaneQ1   = 0;
  localparam int unsigned LaneQ2   = 1;
  localparam int unsigned LaneTh   = 2;
  localparam int unsigned LaneDpdt = 3;

  localparam logic [30:0] Max31    = 31'h7FFF_FFFF;
  localparam logic [47:0] ExpLimit = 48'd786432;
  localparam logic [18:0] Recip6   = 19'd349526;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_RATE_ONE = 3'd2,
    REG_RATE_TWO = 3'd3,
    REG_OMEGA    = 3'd4,
    REG_REF_TEMP = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [50:0] dq;
    logic [32:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic        vinv;
    logic        flag;
    logic        zero1;
    logic        zero2;
    logic [16:0] e1;
    logic [16:0] e2;
    logic        tneg;
    logic        tsat;
  } div_side_t;

  function automatic logic [30:0] exp_int(input logic [3:0] n);
    logic [30:0] v;
    unique case (n)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd395007542;
      4'd2:    v = 31'd145315154;
      4'd3:    v = 31'd53458458;
      4'd4:    v = 31'd19666268;
      4'd5:    v = 31'd7234816;
      4'd6:    v = 31'd2661540;
      4'd7:    v = 31'd979126;
      4'd8:    v = 31'd360200;
      4'd9:    v = 31'd132510;
      4'd10:   v = 31'd48748;
      4'd11:   v = 31'd17933;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] exp_frac(input logic [3:0] j);
    logic [30:0] v;
    unique case (j)
      4'd0:    v = 31'd1073741824;
      4'd1:    v = 31'd1008687096;
      4'd2:    v = 31'd947573834;
      4'd3:    v = 31'd890163237;
      4'd4:    v = 31'd836230973;
      4'd5:    v = 31'd785566300;
      4'd6:    v = 31'd737971244;
      4'd7:    v = 31'd693259859;
      4'd8:    v = 31'd651257337;
      4'd9:    v = 31'd611799649;
      4'd10:   v = 31'd574732582;
      4'd11:   v = 31'd539911296;
      4'd12:   v = 31'd507199724;
      4'd13:   v = 31'd476470059;
      4'd14:   v = 31'd447602185;
      default: v = 31'd420483339;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/jwl_pressure_evaluator.sv
// ----------------------------------------------------------------------------
// jwl_pressure_evaluator
// Throughput: one transaction per cycle while the output is not stalled (in_tready
// is low while out_tvalid waits for out_tready); the 51-row restoring divider chain
// holds up to 51 items at once, and the whole pipeline holds 65.
// Reset (rst_n low, synchronous): pipeline empties, registers take defaults.
// ----------------------------------------------------------------------------
module jwl_pressure_evaluator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // strain_xx, strain_yy, strain_zz, temp_now, mass_density, heat_capacity
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pressure, pressure_dtemp
  output logic [63:0]  out_tdata,
  // overflow, volume_invalid
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import jwl_pkg::*;

  typedef struct packed {
    logic        vinv;
    logic        flag;
    logic [32:0] vol;
    logic [32:0] dt;
    logic [30:0] cv;
    logic [19:0] x1;
    logic [19:0] x2;
    logic        zero1;
    logic        zero2;
    logic [30:0] wrc;
  } carry_t;

  typedef struct packed {
    logic        vinv;
    logic        flag;
    logic        dsat;
    logic [30:0] dval;
    logic [51:0] therm;
  } post_t;

  logic [31:0] coef_a_r;
  logic [31:0] coef_b_r;
  logic [30:0] rate_one_r;
  logic [30:0] rate_two_r;
  logic [30:0] omega_r;
  logic [31:0] ref_temp_r;

  logic        en;
  logic [8:1]  vld_r;
  logic [5:1]  pvld_r;

  logic [33:0] s1_vol_r;
  logic [32:0] s1_dt_r;
  logic [30:0] s1_rho_r;
  logic [30:0] s1_cv_r;

  carry_t      car_r   [2:8];
  carry_t      car_nxt [2:8];

  logic [63:0] x1p;
  logic [63:0] x2p;
  logic [61:0] wrp;
  logic [47:0] x1f_r;
  logic [47:0] x2f_r;
  logic [45:0] wrf_r;
  logic [30:0] wr_r;
  logic [61:0] wrcp;
  logic [45:0] wrcf_r;
  logic signed [64:0] nump;
  logic [63:0] num_r;
  logic [63:0] negnum;
  logic [62:0] mag_r;
  logic        neg7_r;
  logic [62:0] mag8_r;
  logic        neg8_r;
  logic        tsat8_r;
  logic [16:0] e1_x;
  logic [16:0] e2_x;

  logic                     row_vld   [DivSteps+1];
  div_side_t                row_side  [DivSteps+1];
  div_lane_t [NumLanes-1:0] row_lanes [DivSteps+1];

  post_t       p_r   [1:5];
  post_t       p1_nxt;
  post_t       p3_nxt;
  logic [46:0] q1;
  logic [46:0] q2;
  logic [50:0] qt;
  logic [50:0] qd;
  logic [50:0] tm;
  logic signed [48:0] g1_r;
  logic signed [48:0] g2_r;
  logic [16:0] pe1_r;
  logic [16:0] pe2_r;
  logic signed [66:0] ge1p;
  logic signed [66:0] ge2p;
  logic signed [66:0] ge1_r;
  logic signed [66:0] ge2_r;
  logic signed [50:0] sh1;
  logic signed [50:0] sh2;
  logic        sat1;
  logic        sat2;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [31:0] m1_r;
  logic [31:0] m2_r;
  logic signed [63:0] t1p;
  logic signed [63:0] t2p;
  logic [47:0] t1_r;
  logic [47:0] t2_r;
  logic [52:0] tot_nxt;
  logic [52:0] tot_r;

  logic        out_valid_r;
  logic [30:0] out_press_r;
  logic [31:0] out_dpdt_r;
  logic        out_ovf_r;
  logic        out_vinv_r;
  logic        psat;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r   <= '0;
      coef_b_r   <= '0;
      rate_one_r <= 31'd65536;
      rate_two_r <= 31'd65536;
      omega_r    <= '0;
      ref_temp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_COEF_A:   coef_a_r   <= cfg_wdata;
        REG_COEF_B:   coef_b_r   <= cfg_wdata;
        REG_RATE_ONE: rate_one_r <= cfg_wdata[30:0];
        REG_RATE_TWO: rate_two_r <= cfg_wdata[30:0];
        REG_OMEGA:    omega_r    <= cfg_wdata[30:0];
        REG_REF_TEMP: ref_temp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[7:1], in_tvalid};
      pvld_r      <= {pvld_r[4:1], row_vld[DivSteps]};
      out_valid_r <= pvld_r[5];
    end
  end

  // front stages
  assign x1p    = rate_one_r * s1_vol_r[32:0];
  assign x2p    = rate_two_r * s1_vol_r[32:0];
  assign wrp    = omega_r * s1_rho_r;
  assign wrcp   = wr_r * car_r[3].cv;
  assign nump   = $signed({1'b0, car_r[5].wrc}) * $signed(car_r[5].dt);
  assign negnum = -num_r;

  always_comb begin
    car_nxt[2]      = '0;
    car_nxt[2].vinv = s1_vol_r[33] || (s1_vol_r == '0);
    car_nxt[2].vol  = s1_vol_r[32:0];
    car_nxt[2].dt   = s1_dt_r;
    car_nxt[2].cv   = s1_cv_r;
    for (int i = 3; i <= 8; i++) begin
      car_nxt[i] = car_r[i-1];
    end
    car_nxt[3].x1    = x1f_r[19:0];
    car_nxt[3].x2    = x2f_r[19:0];
    car_nxt[3].zero1 = (x1f_r == '0);
    car_nxt[3].zero2 = (x2f_r == '0);
    car_nxt[3].flag  = car_r[2].flag || (wrf_r > {15'b0, Max31});
    car_nxt[5].wrc   = (wrcf_r > {15'b0, Max31}) ? Max31 : wrcf_r[30:0];
    car_nxt[5].flag  = car_r[4].flag || (wrcf_r > {15'b0, Max31});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vol_r <= {{2{in_tdata[31]}}, in_tdata[31:0]}
                + {{2{in_tdata[63]}}, in_tdata[63:32]}
                + {{2{in_tdata[95]}}, in_tdata[95:64]} + 34'd65536;
      s1_dt_r  <= {in_tdata[127], in_tdata[127:96]} - {ref_temp_r[31], ref_temp_r};
      s1_rho_r <= in_tdata[158:128];
      s1_cv_r  <= in_tdata[189:159];
      for (int i = 2; i <= 8; i++) begin
        car_r[i] <= car_nxt[i];
      end
      x1f_r   <= x1p[63:16];
      x2f_r   <= x2p[63:16];
      wrf_r   <= wrp[61:16];
      wr_r    <= (wrf_r > {15'b0, Max31}) ? Max31 : wrf_r[30:0];
      wrcf_r  <= wrcp[61:16];
      num_r   <= nump[63:0];
      mag_r   <= num_r[63] ? negnum[62:0] : num_r[62:0];
      neg7_r  <= num_r[63];
      mag8_r  <= mag_r;
      neg8_r  <= neg7_r;
      tsat8_r <= ({21'b0, mag_r[62:51]} >= car_r[7].vol);
    end
  end

  jwl_exp u_exp1 (
    .clk     (clk),
    .en      (en),
    .x_i     (x1f_r[19:0]),
    .small_i (x1f_r < ExpLimit),
    .e_o     (e1_x)
  );

  jwl_exp u_exp2 (
    .clk     (clk),
    .en      (en),
    .x_i     (x2f_r[19:0]),
    .small_i (x2f_r < ExpLimit),
    .e_o     (e2_x)
  );

  // divider chain entry
  always_comb begin
    row_vld[0]             = vld_r[8];
    row_side[0].vinv       = car_r[8].vinv;
    row_side[0].flag       = car_r[8].flag;
    row_side[0].zero1      = car_r[8].zero1;
    row_side[0].zero2      = car_r[8].zero2;
    row_side[0].e1         = e1_x;
    row_side[0].e2         = e2_x;
    row_side[0].tneg       = neg8_r;
    row_side[0].tsat       = tsat8_r;
    row_lanes[0][LaneQ1]   = '{rem: '0, dq: {4'b0, omega_r, 16'b0},
                               dvs: {13'b0, car_r[8].x1}};
    row_lanes[0][LaneQ2]   = '{rem: '0, dq: {4'b0, omega_r, 16'b0},
                               dvs: {13'b0, car_r[8].x2}};
    row_lanes[0][LaneTh]   = '{rem: {21'b0, mag8_r[62:51]}, dq: mag8_r[50:0],
                               dvs: car_r[8].vol};
    row_lanes[0][LaneDpdt] = '{rem: '0, dq: {4'b0, car_r[8].wrc, 16'b0},
                               dvs: car_r[8].vol};
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_row
    jwl_div_row u_row (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (row_vld[k]),
      .side_i  (row_side[k]),
      .lanes_i (row_lanes[k]),
      .valid_o (row_vld[k+1]),
      .side_o  (row_side[k+1]),
      .lanes_o (row_lanes[k+1])
    );
  end

  // back stages
  always_comb begin
    q1 = (omega_r == '0) ? '0 : row_side[DivSteps].zero1 ? {Max31, 16'b0}
       : row_lanes[DivSteps][LaneQ1].dq[46:0];
    q2 = (omega_r == '0) ? '0 : row_side[DivSteps].zero2 ? {Max31, 16'b0}
       : row_lanes[DivSteps][LaneQ2].dq[46:0];
    qt = row_lanes[DivSteps][LaneTh].dq;
    qd = row_lanes[DivSteps][LaneDpdt].dq;
    tm = (row_side[DivSteps].tsat || (qt > (51'd1 << 50))) ? (51'd1 << 50) : qt;
    p1_nxt.vinv  = row_side[DivSteps].vinv;
    p1_nxt.flag  = row_side[DivSteps].flag || ((omega_r != '0) &&
                   (row_side[DivSteps].zero1 || row_side[DivSteps].zero2));
    p1_nxt.dsat  = (qd > {20'b0, Max31});
    p1_nxt.dval  = p1_nxt.dsat ? Max31 : qd[30:0];
    p1_nxt.therm = row_side[DivSteps].tneg ? -{1'b0, tm} : {1'b0, tm};
  end

  assign ge1p = g1_r * $signed({1'b0, pe1_r});
  assign ge2p = g2_r * $signed({1'b0, pe2_r});
  assign sh1  = ge1_r[66:16];
  assign sh2  = ge2_r[66:16];
  assign sat1 = (sh1 > 51'sd2147483647) || (sh1 < -51'sd2147483648);
  assign sat2 = (sh2 > 51'sd2147483647) || (sh2 < -51'sd2147483648);
  assign m1   = (sh1 > 51'sd2147483647) ? 32'h7FFF_FFFF
              : (sh1 < -51'sd2147483648) ? 32'h8000_0000 : sh1[31:0];
  assign m2   = (sh2 > 51'sd2147483647) ? 32'h7FFF_FFFF
              : (sh2 < -51'sd2147483648) ? 32'h8000_0000 : sh2[31:0];
  assign t1p  = $signed(coef_a_r) * $signed(m1_r);
  assign t2p  = $signed(coef_b_r) * $signed(m2_r);
  assign tot_nxt = {{5{t1_r[47]}}, t1_r} + {{5{t2_r[47]}}, t2_r}
                 + {p_r[4].therm[51], p_r[4].therm};
  assign psat = (tot_r[52:31] != '0);

  always_comb begin
    p3_nxt      = p_r[2];
    p3_nxt.flag = p_r[2].flag || sat1 || sat2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[1]  <= p1_nxt;
      g1_r    <= 49'sd65536 - $signed({2'b0, q1});
      g2_r    <= 49'sd65536 - $signed({2'b0, q2});
      pe1_r   <= row_side[DivSteps].e1;
      pe2_r   <= row_side[DivSteps].e2;
      p_r[2]  <= p_r[1];
      ge1_r   <= ge1p;
      ge2_r   <= ge2p;
      p_r[3]  <= p3_nxt;
      m1_r    <= m1;
      m2_r    <= m2;
      p_r[4]  <= p_r[3];
      t1_r    <= t1p[63:16];
      t2_r    <= t2p[63:16];
      p_r[5]  <= p_r[4];
      tot_r   <= tot_nxt;
      if (p_r[5].vinv) begin
        out_press_r <= '0;
        out_dpdt_r  <= '0;
        out_ovf_r   <= 1'b0;
        out_vinv_r  <= 1'b1;
      end else if (tot_r[52]) begin
        out_press_r <= '0;
        out_dpdt_r  <= '0;
        out_ovf_r   <= p_r[5].flag;
        out_vinv_r  <= 1'b0;
      end else begin
        out_press_r <= psat ? Max31 : tot_r[30:0];
        out_dpdt_r  <= {1'b0, p_r[5].dval};
        out_ovf_r   <= p_r[5].flag || psat || p_r[5].dsat;
        out_vinv_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dpdt_r, out_press_r};
  assign out_tuser  = {out_vinv_r, out_ovf_r};

`ifndef ASSERT_OFF
  a_vinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata[62:0] == '0) && !out_tuser[0])
    else $error("invalid volume with nonzero result");

  a_dpdt_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[62])
    else $error("negative dP/dT");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted transaction lost at pipeline entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r) && $stable(pvld_r))
    else $error("pipeline moved during stall");
`endif

endmodule

### hw/rtl/jwl_div_row.sv
// ----------------------------------------------------------------------------
// jwl_div_row
// One restoring division step for all lanes, with the item sideband.
// ----------------------------------------------------------------------------
module jwl_div_row (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           valid_i,
  input  jwl_pkg::div_side_t                             side_i,
  input  jwl_pkg::div_lane_t [jwl_pkg::NumLanes-1:0]     lanes_i,
  output logic                                           valid_o,
  output jwl_pkg::div_side_t                             side_o,
  output jwl_pkg::div_lane_t [jwl_pkg::NumLanes-1:0]     lanes_o
);
  import jwl_pkg::*;

  logic                         valid_r;
  div_side_t                    side_r;
  div_lane_t [NumLanes-1:0]     lanes_r;
  div_lane_t [NumLanes-1:0]     lanes_nxt;

  always_comb begin
    logic [33:0] cat;
    logic [33:0] dif;
    logic        ge;
    for (int i = 0; i < NumLanes; i++) begin
      cat = {lanes_i[i].rem, lanes_i[i].dq[DivSteps-1]};
      dif = cat - {1'b0, lanes_i[i].dvs};
      ge  = (cat >= {1'b0, lanes_i[i].dvs});
      lanes_nxt[i].dvs = lanes_i[i].dvs;
      lanes_nxt[i].rem = ge ? dif[32:0] : cat[32:0];
      lanes_nxt[i].dq  = {lanes_i[i].dq[DivSteps-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_i;
      lanes_r <= lanes_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign lanes_o = lanes_r;

endmodule

### hw/rtl/jwl_exp.sv
// ----------------------------------------------------------------------------
// jwl_exp
// Six-stage exp(-x) approximation: table product times a cubic in the low bits.
// ----------------------------------------------------------------------------
module jwl_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [19:0] x_i,
  input  logic        small_i,
  output logic [16:0] e_o
);
  import jwl_pkg::*;

  logic [25:0] s;
  logic [51:0] sq;
  logic [61:0] tprod;
  logic [47:0] s3p;
  logic [36:0] d6p;
  logic [31:0] pv;
  logic [61:0] ep;
  logic [32:0] rnd;

  logic [25:0] a_s_r;
  logic [21:0] a_s2_r;
  logic [30:0] a_e1_r;
  logic        a_ok_r;
  logic [25:0] b_s_r;
  logic [21:0] b_s2_r;
  logic [17:0] b_s3_r;
  logic [30:0] b_e1_r;
  logic        b_ok_r;
  logic [25:0] c_s_r;
  logic [21:0] c_s2_r;
  logic [15:0] c_d6_r;
  logic [30:0] c_e1_r;
  logic        c_ok_r;
  logic [30:0] d_p_r;
  logic [30:0] d_e1_r;
  logic        d_ok_r;
  logic [31:0] e_e2_r;
  logic        e_ok_r;
  logic [16:0] f_e_r;

  assign s     = {x_i[11:0], 14'b0};
  assign sq    = s * s;
  assign tprod = exp_int(x_i[19:16]) * exp_frac(x_i[15:12]);
  assign s3p   = a_s2_r * a_s_r;
  assign d6p   = b_s3_r * Recip6;
  assign pv    = 32'd1073741824 - {6'b0, c_s_r} + {11'b0, c_s2_r[21:1]} - {16'b0, c_d6_r};
  assign ep    = d_e1_r * d_p_r;
  assign rnd   = {1'b0, e_e2_r} + 33'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      a_s_r  <= s;
      a_s2_r <= sq[51:30];
      a_e1_r <= tprod[60:30];
      a_ok_r <= small_i;
      b_s_r  <= a_s_r;
      b_s2_r <= a_s2_r;
      b_s3_r <= s3p[47:30];
      b_e1_r <= a_e1_r;
      b_ok_r <= a_ok_r;
      c_s_r  <= b_s_r;
      c_s2_r <= b_s2_r;
      c_d6_r <= d6p[36:21];
      c_e1_r <= b_e1_r;
      c_ok_r <= b_ok_r;
      d_p_r  <= pv[30:0];
      d_e1_r <= c_e1_r;
      d_ok_r <= c_ok_r;
      e_e2_r <= ep[61:30];
      e_ok_r <= d_ok_r;
      f_e_r  <= e_ok_r ? rnd[30:14] : '0;
    end
  end

  assign e_o = f_e_r;

endmodule
